FILE: src/pcpd_pkg.sv
// Shared types and constants for the parity-checked prefix code decoder.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pcpd_pkg;

  // Field widths
  localparam int GROUP_W   = 9;
  localparam int DATA_BITS = 8;
  localparam int CODE_W    = 11;
  localparam int LEN_W     = 4;
  localparam int SYM_W     = 8;
  localparam int CNT_W     = 16;

  // Code store geometry: index is the sentinel-prefixed code word
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int STORE_LEN   = 11;

  // One entry of the front-to-back queue
  typedef struct packed {
    logic                 is_table;
    logic [ADDR_W-1:0]    addr;
    logic [SYM_W-1:0]     sym;
    logic [DATA_BITS-1:0] data;
  } q_entry_t;

  // Back-end control returned to the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

  // One result before its last flag is known
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             code_error;
    logic             limit_reached;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BITS,
    ST_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

FILE: src/pcpd_if.sv
// Valid/ready channel interfaces for requests into and results out of the decoder.
// Depends on pcpd_pkg for field widths.
`default_nettype none

interface pcpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [pcpd_pkg::GROUP_W-1:0]  group_bits;
  logic [pcpd_pkg::CODE_W-1:0]   code_bits;
  logic [pcpd_pkg::LEN_W-1:0]    code_length;
  logic [pcpd_pkg::SYM_W-1:0]    symbol_value;

  modport source (output valid, kind, group_bits, code_bits, code_length, symbol_value,
                  input ready);
  modport sink   (input valid, kind, group_bits, code_bits, code_length, symbol_value,
                  output ready);
endinterface

interface pcpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcpd_pkg::SYM_W-1:0]  symbol;
  logic                        code_error;
  logic                        limit_reached;
  logic                        last;

  modport source (output valid, symbol, code_error, limit_reached, last, input ready);
  modport sink   (input valid, symbol, code_error, limit_reached, last, output ready);
endinterface

`default_nettype wire

FILE: src/pcpd_front.sv
// Front end: accepts requests, checks parity and table entries, queues the survivors.
// Depends on pcpd_pkg and pcpd_in_if.
`default_nettype none

module pcpd_front #(
  parameter int MAX_CODE_LEN = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  pcpd_in_if.sink              in,
  output pcpd_pkg::q_entry_t   head,
  output logic                 head_valid,
  input  pcpd_pkg::back_ctrl_t ctrl
);
  import pcpd_pkg::*;

  localparam int Q_DEPTH = 2;
  localparam logic [LEN_W-1:0] MAX_L   = LEN_W'(MAX_CODE_LEN);
  localparam logic [LEN_W-1:0] STORE_L = LEN_W'(STORE_LEN);

  q_entry_t          queue [Q_DEPTH];
  logic              wptr;
  logic              rptr;
  logic [1:0]        fill;
  logic              full;
  logic              accept;
  logic              keep;
  logic              parity_ok;
  logic              len_ok;
  logic [CODE_W-1:0] code_mask;
  logic [ADDR_W-1:0] table_addr;
  q_entry_t          entry;

  // Classification of the incoming request
  always_comb begin
    parity_ok  = ^in.group_bits;
    len_ok     = (in.code_length != '0) && (in.code_length <= STORE_L) &&
                 (in.code_length <= MAX_L);
    code_mask  = CODE_W'((ADDR_W'(1) << in.code_length) - ADDR_W'(1));
    table_addr = (ADDR_W'(1) << in.code_length) | {1'b0, in.code_bits & code_mask};
    keep       = in.kind ? parity_ok : len_ok;
    entry.is_table = !in.kind;
    entry.addr     = table_addr;
    entry.sym      = in.symbol_value;
    entry.data     = in.group_bits[GROUP_W-1:1];
  end

  assign full     = (fill == 2'(Q_DEPTH));
  assign in.ready = !full && !ctrl.clearing;
  assign accept   = in.valid && in.ready;

  assign head       = queue[rptr];
  assign head_valid = (fill != 2'd0);

  // Queue payload
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      queue[wptr] <= entry;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (accept && keep) wptr <= !wptr;
      if (ctrl.pop) rptr <= !rptr;
      unique case ({accept && keep, ctrl.pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/pcpd_back.sv
// Back end: code store, bit-by-bit decode sequencer and result register.
// Depends on pcpd_pkg and pcpd_out_if.
`default_nettype none

module pcpd_back #(
  parameter int MAX_CODE_LEN = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pcpd_pkg::q_entry_t          head,
  input  logic                        head_valid,
  output pcpd_pkg::back_ctrl_t        ctrl,
  input  logic [pcpd_pkg::CNT_W-1:0]  symbol_limit,
  pcpd_out_if.source                  out
);
  import pcpd_pkg::*;

  localparam int PW = MAX_CODE_LEN + 1;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam logic [ADDR_W-1:0] ADDR_CODE0 = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] ADDR_CODE1 = ADDR_W'(3);

  logic [SYM_W-1:0] store [STORE_DEPTH];
  logic [SYM_W-1:0] mem_q;
  logic [SYM_W-1:0] sh0;
  logic [SYM_W-1:0] sh1;

  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [PW-1:0]     part;
  logic [LW-1:0]     plen;
  logic [2:0]        bidx;
  logic [CNT_W-1:0]  count;
  logic              pend_v;
  result_t           pend;
  logic              out_v;
  result_t           out_r;
  logic              out_last;

  logic              cur_bit;
  logic              nxt_bit;
  logic [PW-1:0]     cur_code;
  logic [PW-1:0]     next_code;
  logic [PW-1:0]     start_code;
  logic [PW+ADDR_W-1:0] next_ext;
  logic [PW+ADDR_W-1:0] start_ext;
  logic [LW-1:0]     cur_len;
  logic [SYM_W-1:0]  look;
  logic              hit;
  logic              err;
  logic              produce;
  logic              limit_hit;
  logic              done;
  logic              slot_free;
  logic              adv;
  logic              fin;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SYM_W-1:0]  wr_data;
  logic              push;
  logic              push_last;

  // Decode of the current bit
  always_comb begin
    cur_bit    = head.data[~bidx];
    nxt_bit    = head.data[~(bidx + 3'd1)];
    cur_code   = {part[PW-2:0], cur_bit};
    next_code  = {cur_code[PW-2:0], nxt_bit};
    start_code = {part[PW-2:0], head.data[DATA_BITS-1]};
    next_ext   = {{ADDR_W{1'b0}}, next_code};
    start_ext  = {{ADDR_W{1'b0}}, start_code};
    cur_len    = plen + LW'(1);
    // one-bit codes come from the shadow copies, longer ones from the store
    look       = (cur_len == LW'(1)) ? (cur_bit ? sh1 : sh0) : mem_q;
    hit        = (int'(cur_len) <= STORE_LEN) && (look != '0);
    err        = !hit && (int'(cur_len) >= MAX_CODE_LEN);
    produce    = hit || err;
    limit_hit  = hit && ((count + CNT_W'(1)) == symbol_limit);
    done       = (bidx == 3'd7) || limit_hit;
    slot_free  = !out_v || out.ready;
    adv        = !(produce && pend_v && !slot_free);
    fin        = !pend_v || slot_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (head_valid && !head.is_table && (count < symbol_limit)) state_next = ST_BITS;
      end
      ST_BITS:  if (adv && done) state_next = ST_FLUSH;
      ST_FLUSH: if (fin) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = next_ext[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = head.addr;
    wr_data       = head.sym;
    ctrl.pop      = 1'b0;
    ctrl.clearing = (state == ST_CLEAR);
    push          = 1'b0;
    push_last     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_IDLE: begin
        if (head_valid) begin
          if (head.is_table) begin
            wr_en    = 1'b1;
            ctrl.pop = 1'b1;
          end else if (count >= symbol_limit) begin
            ctrl.pop = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = start_ext[ADDR_W-1:0];
          end
        end
      end
      ST_BITS: begin
        rd_en = adv && !done;
        push  = adv && produce && pend_v;
      end
      ST_FLUSH: begin
        ctrl.pop  = fin;
        push      = fin && pend_v;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Code store
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (rd_en) mem_q <= store[rd_addr];
  end

  // Control and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      sh0      <= '0;
      sh1      <= '0;
      part     <= PW'(1);
      plen     <= '0;
      bidx     <= '0;
      count    <= '0;
      pend_v   <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (wr_en && (wr_addr == ADDR_CODE0)) sh0 <= wr_data;
      if (wr_en && (wr_addr == ADDR_CODE1)) sh1 <= wr_data;
      if (state == ST_IDLE) bidx <= '0;
      if ((state == ST_BITS) && adv) begin
        bidx <= bidx + 3'd1;
        if (produce) begin
          part   <= PW'(1);
          plen   <= '0;
          pend_v <= 1'b1;
        end else begin
          part <= cur_code;
          plen <= cur_len;
        end
        if (hit) count <= count + CNT_W'(1);
      end
      if ((state == ST_FLUSH) && fin) pend_v <= 1'b0;
      if (push) out_v <= 1'b1;
      else if (out.ready) out_v <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == ST_BITS) && adv && produce) begin
      pend.symbol        <= hit ? look : '0;
      pend.code_error    <= err;
      pend.limit_reached <= limit_hit;
    end
    if (push) begin
      out_r    <= pend;
      out_last <= push_last;
    end
  end

  assign out.valid         = out_v;
  assign out.symbol        = out_r.symbol;
  assign out.code_error    = out_r.code_error;
  assign out.limit_reached = out_r.limit_reached;
  assign out.last          = out_last;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BITS) |-> (int'(plen) < MAX_CODE_LEN))
    else $error("partial code held at or past maximum length");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!ctrl.pop && !rd_en))
    else $error("request served during store clear");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_BITS) && adv && hit) |=> (pend_v && (count == $past(count) + CNT_W'(1))))
    else $error("symbol match not recorded");

endmodule

`default_nettype wire

FILE: src/parity_checked_prefix_code_decoder.sv
// Top level of the parity-checked prefix code decoder: limit register, front and back.
// Depends on pcpd_pkg, pcpd_if, pcpd_front and pcpd_back.
//
// Table requests load prefix code words (1 to 11 bits) with nonzero symbols into a
// 4096-entry code store; data requests carry nine bits, eight data bits first-bit-high
// and an odd parity bit, and each accepted group yields up to eight results whose final
// one carries last. After reset the code store is swept to zero, one entry a cycle;
// requests are held off during the sweep while symbol_limit writes are taken. The
// front end takes one request a cycle, while its two-entry queue has room, and drops
// bad parity groups and bad table entries there at once. The back end writes a table
// request into the store; a data group takes one store read to prime the first bit,
// one lookup per data bit, each depending on the previous one through the single read
// port, and a flush step to close out the group; output back pressure stalls it.
`default_nettype none

module parity_checked_prefix_code_decoder #(
  parameter int MAX_CODE_LEN = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pcpd_pkg::CNT_W-1:0] cfg_wdata,
  pcpd_in_if.sink                    in,
  pcpd_out_if.source                 out
);
  import pcpd_pkg::*;

  logic [CNT_W-1:0] symbol_limit;
  q_entry_t         head;
  logic             head_valid;
  back_ctrl_t       ctrl;

  // Symbol limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_limit <= '0;
    end else if (cfg_we) begin
      symbol_limit <= cfg_wdata;
    end
  end

  pcpd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .head       (head),
    .head_valid (head_valid),
    .ctrl       (ctrl)
  );

  pcpd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .ctrl         (ctrl),
    .symbol_limit (symbol_limit),
    .out          (out)
  );

endmodule

`default_nettype wire
